// ===== rtl/rlfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rlfd_pkg;

   localparam int CH_COUNT   = 3;
   localparam int LEVEL_W    = 8;
   localparam int LEN_W      = 15;
   localparam int PROD_W     = LEVEL_W + LEN_W;
   localparam int DIVIDEND_W = PROD_W + 1;
   localparam int REM_W      = LEN_W + 1;
   localparam int STEP_W     = $clog2(LEVEL_W);

   typedef logic [LEVEL_W-1:0]    level_type;
   typedef logic [LEN_W-1:0]      len_type;
   typedef logic [PROD_W-1:0]     prod_type;
   typedef logic [DIVIDEND_W-1:0] dividend_type;

   localparam level_type FULL_SCALE = 8'd255;
   localparam len_type   LEN_MAX    = 15'h7FFF;

   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_SET_ALL   = 3'd1;
   localparam logic [2:0] OP_SET_RED   = 3'd2;
   localparam logic [2:0] OP_SET_GREEN = 3'd3;
   localparam logic [2:0] OP_SET_BLUE  = 3'd4;
   localparam logic [2:0] OP_START     = 3'd5;
   localparam logic [2:0] OP_STOP      = 3'd6;

endpackage

`default_nettype wire

// ===== rtl/rlfd_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in LEVEL_W bits (dividend < divisor * 2**LEVEL_W).
module rlfd_divider
   import rlfd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire dividend_type dividend,
   input  wire len_type      divisor,
   output logic              done,
   output level_type         quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   level_type         quo_ff, quo_in;
   len_type           dsr_ff, dsr_in;

   logic [REM_W-1:0]  shifted;
   logic              geq;

   assign shifted = {rem_ff[REM_W-2:0], quo_ff[LEVEL_W-1]};
   assign geq     = shifted >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         // upper bits are already below the divisor
         rem_in  = dividend[DIVIDEND_W-1:LEVEL_W];
         quo_in  = dividend[LEVEL_W-1:0];
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = geq ? (shifted - {1'b0, dsr_ff}) : shifted;
         quo_in = {quo_ff[LEVEL_W-2:0], geq};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(LEVEL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/rgb_led_fade_dimmer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Three-channel LED controller with linear fade and global dimming. Each
// request carries a command in req_tuser (tick, set all, set one channel,
// start fade, stop fade) and answers with one response holding the dimmed
// duties, the raw levels and the fade flag. A small sequencer runs every
// channel through one shared 8x15 multiplier and one 8-step restoring
// divider. A tick during a fade that does not reach its end interpolates
// and dims all three channels; every other command runs the dimming pass
// only. One request is in work at a time; the next is taken while the
// previous response waits on rsp_tready. The user must write brightness
// through the csr port only while the block is idle; the block itself does not enforce this.
module rgb_led_fade_dimmer
   import rlfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // red_value[7:0], green_value[15:8], blue_value[23:16], fade_length[38:24]
   input  wire logic [39:0] req_tdata,
   // opcode[2:0]
   input  wire logic [2:0]  req_tuser,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // red_duty[7:0], green_duty[15:8], blue_duty[23:16], red_level[31:24],
   // green_level[39:32], blue_level[47:40], fade_active[48]
   output logic [55:0]      rsp_tdata,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  ch_ff, ch_in;
   logic        dim_ff, dim_in;
   logic        running_ff, running_in;
   logic        falling_ff, falling_in;
   logic        rsp_valid_ff, rsp_valid_in;
   level_type   brightness_ff, brightness_in;
   level_type   current_ff [CH_COUNT];
   level_type   current_in [CH_COUNT];
   level_type   start_ff   [CH_COUNT];
   level_type   start_in   [CH_COUNT];
   level_type   target_ff  [CH_COUNT];
   level_type   target_in  [CH_COUNT];
   level_type   duty_ff    [CH_COUNT];
   level_type   duty_in    [CH_COUNT];
   len_type     duration_ff, duration_in;
   len_type     elapsed_ff, elapsed_in;
   prod_type    product_ff, product_in;
   logic [55:0] rsp_data_ff, rsp_data_in;

   level_type    req_value [CH_COUNT];
   len_type      req_len;
   len_type      elapsed_next;
   level_type    cur_start, cur_target, diff, mul_a;
   len_type      mul_b;
   logic         fall_now;
   dividend_type div_dividend;
   len_type      div_divisor;
   logic         div_start, div_done;
   level_type    div_quotient;

   assign req_value[0] = req_tdata[7:0];
   assign req_value[1] = req_tdata[15:8];
   assign req_value[2] = req_tdata[23:16];
   assign req_len      = req_tdata[38:24];

   assign elapsed_next = (elapsed_ff == LEN_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   // shared multiplier operands: |target - start| * elapsed, or level * brightness
   assign cur_start  = start_ff[ch_ff];
   assign cur_target = target_ff[ch_ff];
   assign fall_now   = cur_target < cur_start;
   assign diff       = fall_now ? (cur_start - cur_target) : (cur_target - cur_start);
   assign mul_a      = dim_ff ? current_ff[ch_ff] : diff;
   assign mul_b      = dim_ff ? {{(LEN_W - LEVEL_W){1'b0}}, brightness_ff} : elapsed_ff;

   // falling levels round the step up so the level rounds toward minus infinity
   assign div_dividend = {1'b0, product_ff}
                       + ((falling_ff && !dim_ff)
                          ? {{(DIVIDEND_W - LEN_W){1'b0}}, duration_ff - 1'b1}
                          : '0);
   assign div_divisor  = dim_ff ? {{(LEN_W - LEVEL_W){1'b0}}, FULL_SCALE} : duration_ff;
   assign div_start    = (state_ff == ST_LOAD);

   rlfd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      dim_in        = dim_ff;
      running_in    = running_ff;
      falling_in    = falling_ff;
      rsp_valid_in  = rsp_valid_ff;
      brightness_in = brightness_ff;
      current_in    = current_ff;
      start_in      = start_ff;
      target_in     = target_ff;
      duty_in       = duty_ff;
      duration_in   = duration_ff;
      elapsed_in    = elapsed_ff;
      product_in    = product_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_valid) begin
         brightness_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // by default go straight to the dimming pass
               dim_in   = 1'b1;
               ch_in    = 2'd0;
               state_in = ST_MUL;
               case (req_tuser)
                  OP_TICK: begin
                     if (running_ff) begin
                        elapsed_in = elapsed_next;
                        if (elapsed_next >= duration_ff) begin
                           current_in = target_ff;
                           running_in = 1'b0;
                        end else begin
                           dim_in = 1'b0;
                        end
                     end
                  end
                  OP_SET_ALL: begin
                     current_in = req_value;
                  end
                  OP_SET_RED: begin
                     current_in[0] = req_value[0];
                  end
                  OP_SET_GREEN: begin
                     current_in[1] = req_value[1];
                  end
                  OP_SET_BLUE: begin
                     current_in[2] = req_value[2];
                  end
                  OP_START: begin
                     start_in    = current_ff;
                     target_in   = req_value;
                     duration_in = req_len;
                     elapsed_in  = '0;
                     running_in  = 1'b1;
                  end
                  OP_STOP: begin
                     running_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            product_in = {{LEN_W{1'b0}}, mul_a} * {{LEVEL_W{1'b0}}, mul_b};
            falling_in = fall_now;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (dim_ff) begin
                  duty_in[ch_ff] = div_quotient;
               end else if (falling_ff) begin
                  current_in[ch_ff] = cur_start - div_quotient;
               end else begin
                  current_in[ch_ff] = cur_start + div_quotient;
               end
               if (ch_ff == 2'(CH_COUNT - 1)) begin
                  ch_in    = 2'd0;
                  dim_in   = 1'b1;
                  state_in = dim_ff ? ST_DONE : ST_MUL;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {7'b0, running_ff,
                               current_ff[2], current_ff[1], current_ff[0],
                               duty_ff[2], duty_ff[1], duty_ff[0]};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ch_ff         <= 2'd0;
         dim_ff        <= 1'b0;
         running_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         brightness_ff <= FULL_SCALE;
         current_ff    <= '{default: '0};
         start_ff      <= '{default: '0};
         target_ff     <= '{default: '0};
         duration_ff   <= '0;
         elapsed_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         ch_ff         <= ch_in;
         dim_ff        <= dim_in;
         running_ff    <= running_in;
         rsp_valid_ff  <= rsp_valid_in;
         brightness_ff <= brightness_in;
         current_ff    <= current_in;
         start_ff      <= start_in;
         target_ff     <= target_in;
         duration_ff   <= duration_in;
         elapsed_ff    <= elapsed_in;
      end
      falling_ff  <= falling_in;
      duty_ff     <= duty_in;
      product_ff  <= product_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

`default_nettype wire
